// ===== design/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define ASSERT_CLKRST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Assertion that is checked during reset as well.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== design/g711c_pkg.sv =====
// ============================================================================
// g711c_pkg
// Function codes, decode expansions and encoder decision thresholds.
// ============================================================================
`default_nettype none

package g711c_pkg;

   localparam logic [1:0] FUNC_ENC_ALAW = 2'd0;
   localparam logic [1:0] FUNC_ENC_ULAW = 2'd1;
   localparam logic [1:0] FUNC_DEC_ALAW = 2'd2;
   localparam logic [1:0] FUNC_DEC_ULAW = 2'd3;

   localparam logic [7:0] ALAW_MASK = 8'hd5;
   localparam logic [7:0] ULAW_MASK = 8'hff;
   localparam int         THR_COUNT = 127;

   typedef logic [12:0] thr_table_type [0:THR_COUNT-1];

   function automatic logic signed [15:0] dec_alaw(input logic [7:0] code);
      logic [7:0]  a;
      logic [15:0] t;
      a = code ^ 8'h55;
      if (a[6:4] != 3'd0) begin
         t = (16'({a[3:0], 1'b1}) + 16'd32) << ({1'b0, a[6:4]} + 4'd2);
      end else begin
         t = 16'({a[3:0], 1'b1}) << 3;
      end
      return a[7] ? t : (16'd0 - t);
   endfunction

   function automatic logic signed [15:0] dec_ulaw(input logic [7:0] code);
      logic [7:0]  u;
      logic [15:0] t;
      u = ~code;
      t = (16'({u[3:0], 3'b000}) + 16'h0084) << u[6:4];
      return u[7] ? (16'h0084 - t) : (t - 16'h0084);
   endfunction

   function automatic logic signed [15:0] dec_law(input logic mu, input logic [7:0] code);
      return mu ? dec_ulaw(code) : dec_alaw(code);
   endfunction

   // midpoint between neighboring positive levels, scaled to the 13-bit magnitude
   function automatic thr_table_type build_thr(input logic mu);
      thr_table_type tab;
      logic [7:0]    mask;
      logic [16:0]   sum;
      logic [15:0]   v1;
      logic [15:0]   v2;
      mask = mu ? ULAW_MASK : ALAW_MASK;
      for (int i = 0; i < THR_COUNT; i++) begin
         v1     = dec_law(mu, 8'(i) ^ mask);
         v2     = dec_law(mu, 8'(i + 1) ^ mask);
         sum    = {1'b0, v1} + {1'b0, v2} + 17'd4;
         tab[i] = sum[15:3];
      end
      return tab;
   endfunction

   localparam thr_table_type ALAW_THR = build_thr(1'b0);
   localparam thr_table_type ULAW_THR = build_thr(1'b1);

endpackage

`default_nettype wire

// ===== design/g711c_decoder.sv =====
// ============================================================================
// g711c_decoder
// Expands an 8-bit A-law or mu-law code byte to a signed linear sample.
// ============================================================================
`default_nettype none

module g711c_decoder (
   input  wire logic               mu,
   input  wire logic [7:0]         law_code,
   output logic signed [15:0]      linear
);

   assign linear = g711c_pkg::dec_law(mu, law_code);

endmodule

`default_nettype wire

// ===== design/g711c_encoder.sv =====
// ============================================================================
// g711c_encoder
// Rounds a signed linear sample to the nearest A-law or mu-law code byte.
// ============================================================================
`default_nettype none

module g711c_encoder (
   input  wire logic               mu,
   input  wire logic signed [15:0] pcm_sample,
   output logic [7:0]              code
);

   logic [12:0]                          mag;
   logic [g711c_pkg::THR_COUNT-1:0]      ge;
   logic [6:0]                           idx;
   logic [6:0]                           probe;
   logic [7:0]                           mask;

   always_comb begin
      if (!pcm_sample[15]) begin
         mag = pcm_sample[14:2];
      end else if (pcm_sample[14:2] == 13'd0) begin
         mag = 13'h1fff;
      end else begin
         mag = (~pcm_sample[14:2]) + 13'd1;
      end
   end

   // thresholds rise with the code index, so ge is a thermometer code
   always_comb begin
      for (int j = 0; j < g711c_pkg::THR_COUNT; j++) begin
         ge[j] = mu ? (mag >= g711c_pkg::ULAW_THR[j]) : (mag >= g711c_pkg::ALAW_THR[j]);
      end
   end

   // binary search for the first threshold above the magnitude
   always_comb begin
      idx   = 7'd0;
      probe = 7'd0;
      for (int k = 6; k >= 0; k--) begin
         probe = idx + 7'((1 << k) - 1);
         if (ge[probe]) begin
            idx = idx | 7'(1 << k);
         end
      end
   end

   assign mask = mu ? g711c_pkg::ULAW_MASK : g711c_pkg::ALAW_MASK;
   assign code = ({1'b0, idx} ^ mask) ^ {pcm_sample[15], 7'd0};

endmodule

`default_nettype wire

// ===== design/g711_alaw_ulaw_codec.sv =====
// ============================================================================
// g711_alaw_ulaw_codec
// Requests go into the input registers, results into the result registers.
// Throughput: one transaction per cycle unless the response is held; then the
// result registers stall, and the input registers once they are full too.
// Synchronous active-high reset clears both valid flags.
// ============================================================================
`default_nettype none

module g711_alaw_ulaw_codec (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [15:0] req_pcm_sample,
   input  wire logic [7:0]         req_law_code,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_code_out,
   output logic signed [15:0]      rsp_linear_out
);

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [1:0]         func_ff;
   logic signed [15:0] pcm_ff;
   logic [7:0]         law_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [7:0]         code_ff;
   logic [7:0]         code_in;
   logic signed [15:0] linear_ff;
   logic signed [15:0] linear_in;
   logic               out_free;
   logic               advance;
   logic               req_take;
   logic [7:0]         enc_code;
   logic signed [15:0] dec_linear;
   logic               is_decode;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign is_decode = (func_ff == g711c_pkg::FUNC_DEC_ALAW) ||
                      (func_ff == g711c_pkg::FUNC_DEC_ULAW);

   g711c_encoder u_encoder (
      .mu         (func_ff == g711c_pkg::FUNC_ENC_ULAW),
      .pcm_sample (pcm_ff),
      .code       (enc_code)
   );

   g711c_decoder u_decoder (
      .mu       (func_ff == g711c_pkg::FUNC_DEC_ULAW),
      .law_code (law_ff),
      .linear   (dec_linear)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !out_free);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
      code_in      = is_decode ? 8'd0 : enc_code;
      linear_in    = is_decode ? dec_linear : 16'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_func;
         pcm_ff  <= req_pcm_sample;
         law_ff  <= req_law_code;
      end
      if (advance) begin
         code_ff   <= code_in;
         linear_ff <= linear_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_out   = code_ff;
   assign rsp_linear_out = linear_ff;

endmodule

`default_nettype wire

// ===== design/g711c_checker.sv =====
// ============================================================================
// g711c_checker
// Port-level checks on the codec's handshakes and response fields.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module g711c_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [7:0]         rsp_code_out,
   input wire logic signed [15:0] rsp_linear_out
);

   // stalled response holds
   `ASSERT_CLKRST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_out) && $stable(rsp_linear_out))

   // only one of the two result fields carries data
   `ASSERT_CLKRST(a_one_field, clock, reset, rsp_valid |-> (rsp_code_out == 8'd0 || rsp_linear_out == 16'sd0))

   // a free response side never stalls the request side
   `ASSERT_CLKRST(a_no_backpressure, clock, reset, rsp_ready |-> req_ready)

   // response valid after the request passes the input and result registers, if the response side is ready in between
   `ASSERT_CLKRST(a_latency, clock, reset, (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)

   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind g711_alaw_ulaw_codec g711c_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: G.711 A-law / mu-law codec testbench
// Drives encode and decode transactions through the valid/ready request
// channel and checks every response, field by field and in order, against a
// behavioral codec model. Directed corner samples and codes come first, then
// random traffic with sender and receiver idling, a long receiver stall and
// a full drain between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      logic [7:0]         code;
      logic signed [15:0] linear;
   } codec_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func = g711c_pkg::FUNC_ENC_ALAW;
   logic signed [15:0] req_pcm_sample = '0;
   logic [7:0]         req_law_code = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_code_out;
   logic signed [15:0] rsp_linear_out;

   codec_result_type expected_results[$];
   int               error_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hold_left = 0;
   int               stall_count = 0;

   g711_alaw_ulaw_codec dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_pcm_sample (req_pcm_sample),
      .req_law_code   (req_law_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_out   (rsp_code_out),
      .rsp_linear_out (rsp_linear_out)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic int alaw_level(input logic [7:0] code);
      logic [7:0] a;
      int         mag;
      a = code ^ 8'h55;
      if (a[6:4] == 3'd0) begin
         mag = (int'(a[3:0]) * 2 + 1) * 8;
      end else begin
         mag = (int'(a[3:0]) * 2 + 33) << (int'(a[6:4]) + 2);
      end
      return a[7] ? mag : -mag;
   endfunction

   function automatic int ulaw_level(input logic [7:0] code);
      logic [7:0] u;
      int         mag;
      u = ~code;
      mag = (int'(u[3:0]) * 8 + 132) << int'(u[6:4]);
      return u[7] ? 132 - mag : mag - 132;
   endfunction

   function automatic int law_level(input logic mu, input logic [7:0] code);
      return mu ? ulaw_level(code) : alaw_level(code);
   endfunction

   // decision point between code index i and i+1, in 13-bit magnitude units
   function automatic int decision_level(input logic mu, input int i);
      logic [7:0] mask;
      int         lo;
      int         hi;
      mask = mu ? g711c_pkg::ULAW_MASK : g711c_pkg::ALAW_MASK;
      if (i >= 127) return 8192;
      lo = law_level(mu, 8'(i) ^ mask);
      hi = law_level(mu, 8'(i + 1) ^ mask);
      return (lo + hi + 4) >>> 3;
   endfunction

   function automatic logic [7:0] encode_sample(input logic mu, input logic signed [15:0] s);
      logic [7:0] mask;
      int         sv;
      int         idx;
      int         m;
      int         i;
      logic       neg;
      mask = mu ? g711c_pkg::ULAW_MASK : g711c_pkg::ALAW_MASK;
      sv   = s;
      idx  = (sv + 32768) >>> 2;
      neg  = sv < 0;
      if (neg) begin
         m = 8192 - idx;
         if (m > 8191) m = 8191;
      end else begin
         m = idx - 8192;
      end
      i = 0;
      while (i < 127 && m >= decision_level(mu, i)) i++;
      return 8'(i) ^ mask ^ (neg ? 8'h80 : 8'h00);
   endfunction

   function automatic codec_result_type predict_codec(input logic [1:0] f,
                                                      input logic signed [15:0] s,
                                                      input logic [7:0] c);
      codec_result_type r;
      r = '0;
      case (f)
         g711c_pkg::FUNC_ENC_ALAW: r.code = encode_sample(1'b0, s);
         g711c_pkg::FUNC_ENC_ULAW: r.code = encode_sample(1'b1, s);
         g711c_pkg::FUNC_DEC_ALAW: r.linear = 16'(alaw_level(c));
         g711c_pkg::FUNC_DEC_ULAW: r.linear = 16'(ulaw_level(c));
         default: r = '0;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------- sender
   task automatic send_item(input logic [1:0] f, input logic signed [15:0] s,
                            input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_pcm_sample <= s;
      req_law_code   <= c;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(predict_codec(f, s, c));
   endtask

   task automatic wait_for_results();
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // ----------------------------------------------------- receiver / check
   always @(posedge clock) begin
      codec_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response transaction: code %02h linear %0d",
                   rsp_code_out, rsp_linear_out);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_code_out !== exp_r.code) begin
               $error("code_out: expected %02h, actual %02h", exp_r.code, rsp_code_out);
               error_count++;
            end
            if (rsp_linear_out !== exp_r.linear) begin
               $error("linear_out: expected %0d, actual %0d", exp_r.linear, rsp_linear_out);
               error_count++;
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // no transaction on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count + 1 >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------- stimulus
   function automatic logic signed [15:0] random_sample(input logic mu);
      int pick;
      int mm;
      int s;
      pick = $urandom_range(2);
      if (pick == 0) begin
         s = $signed(16'($urandom));
      end else if (pick == 1) begin
         s = $urandom_range(2047);
         if ($urandom_range(1)) s = -s;
      end else begin
         // land next to a decision point
         mm = decision_level(mu, $urandom_range(126)) + $urandom_range(2) - 1;
         if (mm < 0) mm = 0;
         if (mm > 8191) mm = 8191;
         s = mm * 4 + $urandom_range(3);
         if ($urandom_range(1)) s = -s;
      end
      return 16'(s);
   endfunction

   task automatic test_directed();
      logic signed [15:0] samples[5];
      logic [7:0]         codes[6];
      samples = '{-16'sd32768, -16'sd32764, -16'sd1, 16'sd0, 16'sd32767};
      codes   = '{8'h00, 8'h55, 8'h7f, 8'h80, 8'hd5, 8'hff};
      send_idle_pct = 0;
      recv_idle_pct = 0;
      foreach (samples[k]) begin
         send_item(g711c_pkg::FUNC_ENC_ALAW, samples[k], 8'($urandom));
         send_item(g711c_pkg::FUNC_ENC_ULAW, samples[k], 8'($urandom));
      end
      send_item(g711c_pkg::FUNC_ENC_ALAW, -16'sd32765, 8'hff);
      foreach (codes[k]) begin
         send_item(g711c_pkg::FUNC_DEC_ALAW, 16'($urandom), codes[k]);
         send_item(g711c_pkg::FUNC_DEC_ULAW, 16'($urandom), codes[k]);
      end
      req_valid <= 1'b0;
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
      logic [1:0] f;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) begin
         f = 2'($urandom_range(3));
         send_item(f, random_sample(f[0]), 8'($urandom));
      end
      req_valid <= 1'b0;
      wait_for_results();
   endtask

   // receiver holds off while the sender keeps pushing; input must stall
   task automatic test_backpressure();
      logic [1:0] f;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = HOLD_CYCLES;
      repeat (30) begin
         f = 2'($urandom_range(3));
         send_item(f, random_sample(f[0]), 8'($urandom));
      end
      req_valid <= 1'b0;
      wait_for_results();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(340, 24, 47);
      test_backpressure();
      test_random_traffic(340, 47, 24);
      test_random_traffic(340, 0, 0);
      repeat (4) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== g711_alaw_ulaw_codec.f =====
+incdir+design
design/g711c_pkg.sv
design/g711c_decoder.sv
design/g711c_encoder.sv
design/g711_alaw_ulaw_codec.sv
design/g711c_checker.sv
tb/sv/tb.sv
